// File: hw/rtl/overwriting_ring_buffer_core_macros.svh
// Assertion macros for the overwriting ring buffer core.
`ifndef OVERWRITING_RING_BUFFER_CORE_MACROS_SVH
`define OVERWRITING_RING_BUFFER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define ORBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define ORBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ORBC_ASSERT(lbl, prop, msg)
`define ORBC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/orbc_pkg.sv
// Shared types and constants of the overwriting ring buffer.
`default_nettype none
package orbc_pkg;

  localparam int CmdW      = 2;
  localparam int PeekIdxW  = 6;
  localparam int CapCfgW   = 5;
  localparam int CapMax    = 31;
  localparam int CapReset  = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic cfg_wr;
    logic start;
    logic load_out;
    logic take_out;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/orbc_in_if.sv
// Command channel: command, push word and peek offset.
`default_nettype none
interface orbc_in_if
  import orbc_pkg::*;
#(
  parameter int DATA_WIDTH = 32
);
  logic                       valid;
  logic                       ready;
  logic [CmdW-1:0]            cmd;
  logic [DATA_WIDTH-1:0]      push_data;
  logic signed [PeekIdxW-1:0] peek_index;

  modport source (output valid, output cmd, output push_data, output peek_index,
                  input ready);
  modport sink   (input valid, input cmd, input push_data, input peek_index,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/orbc_out_if.sv
// Result channel: returned word and its valid flag.
`default_nettype none
interface orbc_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] result_data;
  logic                  result_valid;

  modport source (output valid, output result_data, output result_valid, input ready);
  modport sink   (input valid, input result_data, input result_valid, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/orbc_cfg_if.sv
// Configuration channel: capacity write.
`default_nettype none
interface orbc_cfg_if
  import orbc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CapCfgW-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/orbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module orbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// File: hw/rtl/orbc_ctrl.sv
// Controller: sequences one command through the slot store and the output register.
`default_nettype none
module orbc_ctrl
  import orbc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic out_ready_i,
  input  wire logic cfg_valid_i,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o,
  output logic      in_ready_o,
  output logic      cfg_ready_o
);
  state_e state_q, state_d;
  logic   load_ok;

  assign load_ok = !sts_i.out_full || out_ready_i;

  always_comb begin
    state_d        = state_q;
    ctl_o.cfg_wr   = cfg_valid_i;
    ctl_o.start    = 1'b0;
    ctl_o.load_out = 1'b0;
    ctl_o.take_out = out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.start = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold the read word until the output register is free
        if (load_ok) begin
          ctl_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/orbc_dpath.sv
// Datapath: pointers, valid bits, slot store and output register.
`default_nettype none
module orbc_dpath
  import orbc_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ctl_t                       ctl_i,
  output sts_t                            sts_o,
  input  wire logic [CmdW-1:0]            cmd_i,
  input  wire logic [DATA_WIDTH-1:0]      push_data_i,
  input  wire logic signed [PeekIdxW-1:0] peek_index_i,
  input  wire logic [CapCfgW-1:0]         capacity_i,
  output logic                            out_valid_o,
  output logic [DATA_WIDTH-1:0]           result_data_o,
  output logic                            result_valid_o
);
  // Only slots below the largest writable capacity are ever addressed
  localparam int Slots  = (DEPTH < CapMax) ? DEPTH : CapMax;
  localparam int IdxW   = $clog2(Slots);
  localparam int CapW   = $clog2(Slots + 1);
  localparam int CapRst = (Slots < CapReset) ? Slots : CapReset;
  localparam logic [CapCfgW-1:0] SlotsCfg = CapCfgW'(Slots);

  logic [CapW-1:0]       cap_q, cap_d;
  logic [IdxW-1:0]       head_q, head_d;
  logic [IdxW-1:0]       tail_q, tail_d;
  logic                  empty_q, empty_d;
  logic [Slots-1:0]      valid_q, valid_d;
  logic                  hit_q, hit_d;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic                  out_hit_q;

  logic [IdxW-1:0]       raddr;
  logic [IdxW-1:0]       head_next, tail_next, peek_pos;
  logic                  peek_ok;
  logic [PeekIdxW-1:0]   idx_u, cap_x, pos_sum;
  logic [CapW-1:0]       cap_clamped;
  logic                  push_we;
  logic [DATA_WIDTH-1:0] ram_rdata;

  function automatic logic [IdxW-1:0] wrap_next(input logic [IdxW-1:0] v,
                                                input logic [CapW-1:0] cap);
    logic [CapW-1:0] inc;
    inc = CapW'(v) + CapW'(1);
    return (inc >= cap) ? '0 : IdxW'(inc);
  endfunction

  always_comb begin
    if (capacity_i == '0) begin
      cap_clamped = CapW'(1);
    end else if (capacity_i > SlotsCfg) begin
      cap_clamped = CapW'(Slots);
    end else begin
      cap_clamped = CapW'(capacity_i);
    end
  end

  assign head_next = wrap_next(head_q, cap_q);
  assign tail_next = wrap_next(tail_q, cap_q);

  // Peek position: newest for a negative offset, else tail plus offset wrapped once
  always_comb begin
    idx_u   = peek_index_i;
    cap_x   = PeekIdxW'(cap_q);
    pos_sum = PeekIdxW'(tail_q) + idx_u;
    if (pos_sum >= cap_x) begin
      pos_sum = pos_sum - cap_x;
    end
    if (peek_index_i < 0) begin
      peek_ok  = 1'b1;
      peek_pos = (head_q == '0) ? IdxW'(cap_q - CapW'(1)) : head_q - IdxW'(1);
    end else begin
      peek_ok  = (idx_u < cap_x);
      peek_pos = IdxW'(pos_sum);
    end
  end

  always_comb begin
    cap_d   = cap_q;
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    valid_d = valid_q;
    hit_d   = hit_q;
    raddr   = tail_q;
    push_we = 1'b0;
    if (ctl_i.cfg_wr) begin
      cap_d   = cap_clamped;
      head_d  = '0;
      tail_d  = '0;
      empty_d = 1'b1;
      valid_d = '0;
    end else if (ctl_i.start) begin
      hit_d = 1'b0;
      case (cmd_e'(cmd_i))
        CMD_PUSH: begin
          raddr   = head_q;
          push_we = 1'b1;
          hit_d   = valid_q[head_q];
          // evict the oldest word when the head slot is still occupied
          if (valid_q[head_q]) begin
            tail_d = head_next;
          end else if (empty_q) begin
            tail_d = head_q;
          end
          valid_d[head_q] = 1'b1;
          empty_d         = 1'b0;
          head_d          = head_next;
        end
        CMD_POP: begin
          raddr = tail_q;
          if (!empty_q) begin
            hit_d           = valid_q[tail_q];
            valid_d[tail_q] = 1'b0;
            tail_d          = tail_next;
            if (tail_next == head_q) begin
              empty_d = 1'b1;
            end
          end
        end
        CMD_PEEK: begin
          raddr = peek_pos;
          if (!empty_q && peek_ok) begin
            hit_d = valid_q[peek_pos];
          end
        end
        default: begin
          hit_d = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (ctl_i.take_out) begin
      out_valid_d = 1'b0;
    end
  end

  orbc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (Slots)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (push_we),
    .waddr_i (head_q),
    .wdata_i (push_data_i),
    .re_i    (ctl_i.start),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapW'(CapRst);
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    if (ctl_i.load_out) begin
      out_data_q <= hit_q ? ram_rdata : '0;
      out_hit_q  <= hit_q;
    end
  end

  assign sts_o.out_full  = out_valid_q;
  assign out_valid_o     = out_valid_q;
  assign result_data_o   = out_data_q;
  assign result_valid_o  = out_hit_q;
endmodule
`default_nettype wire

// File: hw/rtl/overwriting_ring_buffer_core.sv
// Top level of the overwriting ring buffer: controller, datapath and checks.
//
//   channel | dir | payload                          | transfer when
//   in_i    | in  | cmd, push_data, peek_index       | in_i.valid & in_i.ready
//   out_o   | out | result_data, result_valid        | out_o.valid & out_o.ready
//   cfg_i   | in  | capacity                         | cfg_i.valid & cfg_i.ready
//
// In S_IDLE a command updates pointers and valid bits and starts the slot RAM
// access; in S_EXEC the registered read word moves to the output register.
// No new command is taken until the controller is back in idle, which it only
// reaches once the registered read word has moved into the output register.
// The output register holds a result while the next command is taken; a
// stalled output holds the second command in S_EXEC.
// Reset is asynchronous and immediate: buffer empty, capacity sixteen (or DEPTH).
`default_nettype none
`include "overwriting_ring_buffer_core_macros.svh"
module overwriting_ring_buffer_core
  import orbc_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  orbc_in_if.sink     in_i,
  orbc_out_if.source  out_o,
  orbc_cfg_if.sink    cfg_i
);
  ctl_t ctl;
  sts_t sts;

  orbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .cfg_valid_i (cfg_i.valid),
    .sts_i       (sts),
    .ctl_o       (ctl),
    .in_ready_o  (in_i.ready),
    .cfg_ready_o (cfg_i.ready)
  );

  orbc_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .cmd_i          (in_i.cmd),
    .push_data_i    (in_i.push_data),
    .peek_index_i   (in_i.peek_index),
    .capacity_i     (cfg_i.capacity),
    .out_valid_o    (out_o.valid),
    .result_data_o  (out_o.result_data),
    .result_valid_o (out_o.result_valid)
  );

  `ORBC_ASSERT(a_busy_after_transfer, (in_i.valid && in_i.ready) |=> !in_i.ready, "taken while busy")
  `ORBC_ASSERT(a_load_into_free, ctl.load_out |-> (!sts.out_full || out_o.ready), "result overwritten")
  `ORBC_ASSERT(a_start_load_apart, !(ctl.start && ctl.load_out), "start and load in one cycle")
  `ORBC_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |=> !out_o.valid, "result offered after reset")
endmodule
`default_nettype wire

// File: sim/tb_overwriting_ring_buffer_core.sv
// Self-checking testbench for the overwriting ring buffer core.
`timescale 1ns / 100ps
module tb_overwriting_ring_buffer_core;
  import orbc_pkg::*;

  localparam int WORD_W         = 32;
  localparam int SLOTS          = 16;
  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 11;
  localparam int MAX_WAIT       = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 72;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]            cmd;
    logic [WORD_W-1:0]          push_data;
    logic signed [PeekIdxW-1:0] peek_index;
  } ring_cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              ok;
  } ring_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       in_valid  = 1'b0;
  logic [CmdW-1:0]            in_cmd    = '0;
  logic [WORD_W-1:0]          in_data   = '0;
  logic signed [PeekIdxW-1:0] in_offs   = '0;
  logic                       res_ready = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [CapCfgW-1:0]         cfg_cap   = '0;

  orbc_in_if  #(.DATA_WIDTH(WORD_W)) in_bus ();
  orbc_out_if #(.DATA_WIDTH(WORD_W)) out_bus ();
  orbc_cfg_if                        cfg_bus ();

  assign in_bus.valid      = in_valid;
  assign in_bus.cmd        = in_cmd;
  assign in_bus.push_data  = in_data;
  assign in_bus.peek_index = in_offs;
  assign out_bus.ready     = res_ready;
  assign cfg_bus.valid     = cfg_valid;
  assign cfg_bus.capacity  = cfg_cap;

  overwriting_ring_buffer_core #(
    .DEPTH      (SLOTS),
    .DATA_WIDTH (WORD_W)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Shadow copy of the buffer
  logic [WORD_W-1:0]  slot_word [SLOTS];
  bit                 slot_full [SLOTS];
  logic [CapCfgW-1:0] cap_reg    = CapCfgW'(CapReset);
  int                 head_pos   = 0;
  int                 tail_pos   = 0;
  bit                 ring_empty = 1'b1;

  ring_cmd_t    pending_cmds [$];
  ring_result_t expected_results [$];
  ring_cmd_t    cur_cmd;
  int           mismatch_count = 0;
  bit           no_idle = 1'b0;
  int           hold_seq = 0;

  function automatic int active_slots();
    if (cap_reg == 0) return 1;
    if (int'(cap_reg) > SLOTS) return SLOTS;
    return int'(cap_reg);
  endfunction

  function automatic int wrap_inc(input int v, input int c);
    return (v + 1 >= c) ? 0 : v + 1;
  endfunction

  function automatic void ring_configure(input logic [CapCfgW-1:0] value);
    cap_reg = value;
    foreach (slot_full[k]) slot_full[k] = 1'b0;
    head_pos   = 0;
    tail_pos   = 0;
    ring_empty = 1'b1;
  endfunction

  function automatic ring_result_t ring_apply(input ring_cmd_t it);
    ring_result_t r;
    int cap, h, t, offs, pos;
    r    = '0;
    cap  = active_slots();
    h    = head_pos % cap;
    t    = tail_pos % cap;
    offs = $signed(it.peek_index);
    case (it.cmd)
      CMD_PUSH: begin
        if (slot_full[h]) begin
          // Evict the oldest word and move the tail past it
          r.word = slot_word[h];
          r.ok   = 1'b1;
          t      = wrap_inc(h, cap);
        end else if (ring_empty) begin
          t = h;
        end
        slot_word[h] = it.push_data;
        slot_full[h] = 1'b1;
        ring_empty   = 1'b0;
        h            = wrap_inc(h, cap);
      end
      CMD_POP: begin
        if (!ring_empty) begin
          if (slot_full[t]) begin
            r.word = slot_word[t];
            r.ok   = 1'b1;
          end
          slot_full[t] = 1'b0;
          t = wrap_inc(t, cap);
          if (t == h) ring_empty = 1'b1;
        end
      end
      CMD_PEEK: begin
        if (!ring_empty && offs < cap) begin
          if (offs < 0) begin
            pos = (h == 0) ? cap - 1 : h - 1;
          end else begin
            pos = t + offs;
            if (pos >= cap) pos -= cap;
          end
          if (pos < SLOTS && slot_full[pos]) begin
            r.word = slot_word[pos];
            r.ok   = 1'b1;
          end
        end
      end
      default: ;
    endcase
    head_pos = h;
    tail_pos = t;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic queue_cmd(input logic [CmdW-1:0] c, input logic [WORD_W-1:0] w,
                           input int offs);
    ring_cmd_t it;
    it.cmd        = c;
    it.push_data  = w;
    it.peek_index = offs[PeekIdxW-1:0];
    pending_cmds.push_back(it);
  endtask

  function automatic ring_cmd_t random_cmd(input int push_pct);
    ring_cmd_t it;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3)                                   it.cmd = CMD_UNUSED;
    else if (roll < 3 + push_pct)                   it.cmd = CMD_PUSH;
    else if (roll < 3 + push_pct + (97 - push_pct) / 2) it.cmd = CMD_POP;
    else                                            it.cmd = CMD_PEEK;
    case ($urandom_range(0, 9))
      0:       it.push_data = '0;
      1:       it.push_data = '1;
      default: it.push_data = $urandom();
    endcase
    // Mostly meaningful offsets, now and then any 6-bit value
    if ($urandom_range(0, 99) < 85) it.peek_index = PeekIdxW'($urandom_range(0, 17) - 1);
    else                            it.peek_index = PeekIdxW'($urandom());
    return it;
  endfunction

  // Wait until every command has gone through and every result has come back
  task automatic settle();
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapCfgW-1:0] value);
    cfg_cap   <= value;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    ring_configure(value);
    cfg_valid <= 1'b0;
  endtask

  // Command driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_bus.ready) begin
        expected_results.push_back(ring_apply(cur_cmd));
        send_gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!in_valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd  = pending_cmds.pop_front();
          in_cmd   <= cur_cmd.cmd;
          in_data  <= cur_cmd.push_data;
          in_offs  <= cur_cmd.peek_index;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  int stall_left = 0;
  int hold_left  = 0;
  int hold_seen  = 0;
  always @(posedge clk_i) begin
    ring_result_t want;
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (res_ready && out_bus.valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result data %h valid %b",
                                    out_bus.result_data, out_bus.result_valid));
        end else begin
          want = expected_results.pop_front();
          if (out_bus.result_data !== want.word)
            report_mismatch($sformatf("result_data got %h expected %h",
                                      out_bus.result_data, want.word));
          if (out_bus.result_valid !== want.ok)
            report_mismatch($sformatf("result_valid got %b expected %b",
                                      out_bus.result_valid, want.ok));
        end
        stall_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Abort when no transfer happens for too long
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_bus.ready) || (res_ready && out_bus.valid) ||
          (cfg_valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [CapCfgW-1:0] phase_cap [PHASES];
    int push_pct;
    phase_cap = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd2, 5'd16, 5'd8, 5'd3, 5'd16};
    // Randomise two of the settings
    phase_cap[2] = CapCfgW'($urandom_range(1, 15));
    phase_cap[7] = CapCfgW'($urandom_range(0, 31));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset capacity: empty peek, then a word and the newest of it
    queue_cmd(CMD_PEEK, 32'h0, 0);
    queue_cmd(CMD_PUSH, 32'hFFFF_FFFF, 0);
    queue_cmd(CMD_PEEK, 32'h0, -1);
    settle();

    write_capacity(5'd4);
    queue_cmd(CMD_POP, 32'h0, 0);
    queue_cmd(CMD_PUSH, 32'h0000_0000, 0);
    queue_cmd(CMD_PUSH, 32'hFFFF_FFFF, 0);
    queue_cmd(CMD_PUSH, 32'hA5A5_A5A5, 0);
    queue_cmd(CMD_PUSH, 32'h5A5A_5A5A, 0);
    queue_cmd(CMD_PUSH, 32'h1234_5678, 0);   // full: evict
    queue_cmd(CMD_PEEK, 32'h0, -1);
    queue_cmd(CMD_PEEK, 32'h0, 3);
    queue_cmd(CMD_PEEK, 32'h0, 4);           // offset at capacity
    queue_cmd(CMD_PEEK, 32'h0, -32);
    queue_cmd(CMD_PEEK, 32'h0, 31);
    queue_cmd(CMD_UNUSED, 32'hDEAD_BEEF, 1);
    queue_cmd(CMD_POP, 32'h0, 0);
    queue_cmd(CMD_PEEK, 32'h0, 3);           // slot just cleared
    queue_cmd(CMD_POP, 32'h0, 0);
    queue_cmd(CMD_POP, 32'h0, 0);
    queue_cmd(CMD_POP, 32'h0, 0);
    queue_cmd(CMD_POP, 32'h0, 0);            // already empty
    queue_cmd(CMD_PEEK, 32'h0, -1);
    settle();

    write_capacity(5'd0);                    // used as one slot
    queue_cmd(CMD_PUSH, 32'h8000_0001, 0);
    queue_cmd(CMD_PUSH, 32'h7FFF_FFFE, 0);
    queue_cmd(CMD_PEEK, 32'h0, 1);
    queue_cmd(CMD_POP, 32'h0, 0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      no_idle  = (p % 4 == 3) || (p == 6);
      push_pct = (p % 3 == 0) ? 70 : (p % 3 == 1) ? 45 : 85;
      // Hold off the receiver while the sender keeps pushing
      if (p == 6) begin
        push_pct = 90;
        hold_seq++;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) pending_cmds.push_back(random_cmd(push_pct));
      settle();
      no_idle = 1'b0;
    end

    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
